// ===== hdl/grdc_pkg.sv =====
// shared types and constants of the grid ray caster
package grdc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAP_SIDE   = 64;
  localparam int TEX_BITS   = 5;
  localparam int ORG_W      = 22;
  localparam int DIR_W      = 18;
  localparam int ADDR_W     = 12;
  localparam int TILE_W     = 8;
  localparam int SIZE_W     = 7;
  localparam int CELL_W     = 8;
  localparam int QUO_W      = 2 * FRAC_BITS + 1;
  localparam int ACC_W      = QUO_W + 8;
  localparam int DIST_W     = 24;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_CHECK,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic write;
    logic load;
    logic seed;
    logic step;
    logic check;
    logic mul;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic zero_dir;
    logic div_done;
    logic oob;
    logic tile_hit;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/grid_ray_dda_caster.sv =====
// top level of the grid ray caster
// usage:
//   s_axis carries tile writes (tuser 0) and ray casts (tuser 1); a write beat
//   stores one tile and gives no result. a cast beat gives one
//   result beat on m_axis. cfg_* writes map width (index 0) and map height
//   (index 1) and must only be used while no cast is in flight.
// sequence of a cast:
//   the four parallel bit-serial dividers run first, then each grid cell
//   walked takes a step and then a tile read, then the hit coordinate is
//   multiplied and the result is loaded; a zero direction skips straight
//   to loading the result.
// one cast at a time:
//   s_axis_tready is high only while idle, so a new cast starts only after
//   the last has loaded its result. a new beat may be taken while the last result waits.
// reset:
//   clears the control state and sets both size registers to 64; the tile
//   memory is not cleared and must be written before it is read.
// stall:
//   when m_axis_tready is low the result holds and a finished cast waits
//   before it may overwrite it.
module grid_ray_dda_caster (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tile_index, tile_value, origin_x, origin_y, dir_x, dir_y, zero pad
  input  logic [grdc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // func
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // distance, wall_axis, hit_wall, block_kind, hit_fraction, texture_column,
  // cell_x, cell_y, zero pad
  output logic [grdc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [grdc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [grdc_pkg::SIZE_W-1:0]         cfg_data_i
);

  grdc_pkg::cmd_t cmd;
  grdc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  grdc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .func_i     (s_axis_tuser),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  grdc_dpath u_dpath (
    .clk_i, .rst_ni,
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== hdl/grdc_div.sv =====
// restoring divider, one quotient bit per cycle
module grdc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [grdc_pkg::QUO_W-1:0]     dividend_i,
  input  logic [grdc_pkg::DIR_W-1:0]     divisor_i,
  output logic [grdc_pkg::QUO_W-1:0]     quot_o,
  output logic                           done_o
);

  logic [grdc_pkg::QUO_W-1:0] quo_q;
  logic [grdc_pkg::DIR_W-1:0] rem_q, dvs_q;
  logic [5:0]                 cnt_q;
  logic                       busy_q, done_q;
  logic [grdc_pkg::DIR_W:0]   trial;
  logic                       fits;

  assign trial = {rem_q, quo_q[grdc_pkg::QUO_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 6'(grdc_pkg::QUO_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? grdc_pkg::DIR_W'(trial - {1'b0, dvs_q})
                    : trial[grdc_pkg::DIR_W-1:0];
      quo_q <= {quo_q[grdc_pkg::QUO_W-2:0], fits};
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// ===== hdl/grdc_ctrl.sv =====
// sequencer of the ray caster
module grdc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             func_i,
  input  grdc_pkg::sts_t   sts_i,
  output logic             in_ready_o,
  output grdc_pkg::cmd_t   cmd_o
);

  grdc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= grdc_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      grdc_pkg::ST_IDLE: begin
        if (in_valid_i && func_i == grdc_pkg::FUNC_CAST)
          state_d = sts_i.zero_dir ? grdc_pkg::ST_FIN : grdc_pkg::ST_DIV;
      end
      grdc_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = grdc_pkg::ST_STEP;
      end
      grdc_pkg::ST_STEP:  state_d = grdc_pkg::ST_CHECK;
      grdc_pkg::ST_CHECK: begin
        state_d = (sts_i.oob || sts_i.tile_hit) ? grdc_pkg::ST_MUL : grdc_pkg::ST_STEP;
      end
      grdc_pkg::ST_MUL:   state_d = grdc_pkg::ST_FIN;
      grdc_pkg::ST_FIN: begin
        if (sts_i.out_free) state_d = grdc_pkg::ST_IDLE;
      end
      default: state_d = grdc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = state_q == grdc_pkg::ST_IDLE;
    cmd_o      = '0;
    cmd_o.write = in_ready_o && in_valid_i && func_i == grdc_pkg::FUNC_WRITE;
    cmd_o.load  = in_ready_o && in_valid_i && func_i == grdc_pkg::FUNC_CAST;
    cmd_o.seed  = state_q == grdc_pkg::ST_DIV && sts_i.div_done;
    cmd_o.step  = state_q == grdc_pkg::ST_STEP;
    cmd_o.check = state_q == grdc_pkg::ST_CHECK;
    cmd_o.mul   = state_q == grdc_pkg::ST_MUL;
    cmd_o.fin   = state_q == grdc_pkg::ST_FIN && sts_i.out_free;
  end

endmodule

// ===== hdl/grdc_dpath.sv =====
// datapath: tile memory, dividers, side distance walk and result register
module grdc_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [grdc_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic                                cfg_we_i,
  input  logic [grdc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [grdc_pkg::SIZE_W-1:0]         cfg_data_i,
  input  grdc_pkg::cmd_t                      cmd_i,
  output grdc_pkg::sts_t                      sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [grdc_pkg::OUT_DATA_W-1:0]     out_data_o
);

  localparam int F  = grdc_pkg::FRAC_BITS;
  localparam int AW = grdc_pkg::ACC_W;
  localparam int QW = grdc_pkg::QUO_W;
  localparam int CW = grdc_pkg::CELL_W;
  localparam int DW = grdc_pkg::DIR_W;
  localparam int SW = grdc_pkg::SIZE_W;

  logic [grdc_pkg::ADDR_W-1:0] in_idx;
  logic [grdc_pkg::TILE_W-1:0] in_val;
  logic [grdc_pkg::ORG_W-1:0]  in_ox, in_oy;
  logic [DW-1:0]               in_dx, in_dy;

  assign in_idx = in_data_i[11:0];
  assign in_val = in_data_i[19:12];
  assign in_ox  = in_data_i[41:20];
  assign in_oy  = in_data_i[63:42];
  assign in_dx  = in_data_i[81:64];
  assign in_dy  = in_data_i[99:82];

  logic [SW-1:0] width_q, height_q, w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SW'(grdc_pkg::MAP_SIDE);
      height_q <= SW'(grdc_pkg::MAP_SIDE);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        grdc_pkg::REG_MAP_WIDTH:  width_q  <= cfg_data_i;
        grdc_pkg::REG_MAP_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff = width_q  > SW'(grdc_pkg::MAP_SIDE) ? SW'(grdc_pkg::MAP_SIDE) : width_q;
  assign h_eff = height_q > SW'(grdc_pkg::MAP_SIDE) ? SW'(grdc_pkg::MAP_SIDE) : height_q;

  function automatic logic [DW-1:0] magn(input logic [DW-1:0] d);
    magn = d[DW-1] ? DW'(-d) : d;
  endfunction

  function automatic logic [QW-1:0] side_num(input logic [grdc_pkg::ORG_W-1:0] o,
                                             input logic [DW-1:0] d);
    logic [F:0] gap;
    gap = d[DW-1] ? {1'b0, o[F-1:0]} : (F+1)'((F+1)'(1) << F) - {1'b0, o[F-1:0]};
    side_num = QW'(gap) << F;
  endfunction

  // dividers: side and delta per axis
  logic [QW-1:0] q_sx, q_sy, q_dlx, q_dly;
  logic          dn_sx, dn_sy, dn_dlx, dn_dly;
  logic [QW-1:0] one_sq;

  assign one_sq = QW'(1) << (2 * F);

  grdc_div u_div_sx (.clk_i, .rst_ni, .start_i(cmd_i.load), .dividend_i(side_num(in_ox, in_dx)),
                     .divisor_i(magn(in_dx)), .quot_o(q_sx), .done_o(dn_sx));
  grdc_div u_div_sy (.clk_i, .rst_ni, .start_i(cmd_i.load), .dividend_i(side_num(in_oy, in_dy)),
                     .divisor_i(magn(in_dy)), .quot_o(q_sy), .done_o(dn_sy));
  grdc_div u_div_dlx (.clk_i, .rst_ni, .start_i(cmd_i.load), .dividend_i(one_sq),
                      .divisor_i(magn(in_dx)), .quot_o(q_dlx), .done_o(dn_dlx));
  grdc_div u_div_dly (.clk_i, .rst_ni, .start_i(cmd_i.load), .dividend_i(one_sq),
                      .divisor_i(magn(in_dy)), .quot_o(q_dly), .done_o(dn_dly));

  // ray state
  logic [grdc_pkg::ORG_W-1:0] ox_q, oy_q;
  logic [DW-1:0]              dx_q, dy_q;
  logic [AW-1:0]              sx_q, sy_q, dist_q;
  logic [QW-1:0]              dlx_q, dly_q;
  logic signed [CW-1:0]       cx_q, cy_q, cx_d, cy_d;
  logic                       side_q, hit_q, zero_q, oob_q;
  logic [grdc_pkg::TILE_W-1:0] kind_q, rdata_q;
  logic [31:0]                prod_q;
  logic                       take_x, oob_d;
  logic [grdc_pkg::ADDR_W-1:0] raddr;

  always_comb begin
    if (dx_q == '0)      take_x = 1'b0;
    else if (dy_q == '0) take_x = 1'b1;
    else                 take_x = sx_q < sy_q;
    cx_d = cx_q;
    cy_d = cy_q;
    if (take_x) cx_d = dx_q[DW-1] ? cx_q - CW'(1) : cx_q + CW'(1);
    else        cy_d = dy_q[DW-1] ? cy_q - CW'(1) : cy_q + CW'(1);
    oob_d = cx_d[CW-1] || cy_d[CW-1] || cx_d[SW-1:0] >= w_eff || cy_d[SW-1:0] >= h_eff;
    raddr = grdc_pkg::ADDR_W'(cx_d[5:0]) + grdc_pkg::ADDR_W'(cy_d[5:0] * w_eff);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ox_q   <= in_ox;
      oy_q   <= in_oy;
      dx_q   <= in_dx;
      dy_q   <= in_dy;
      cx_q   <= CW'(in_ox[grdc_pkg::ORG_W-1:F]);
      cy_q   <= CW'(in_oy[grdc_pkg::ORG_W-1:F]);
      zero_q <= in_dx == '0 && in_dy == '0;
      hit_q  <= 1'b0;
      kind_q <= '0;
      side_q <= 1'b0;
    end
    if (cmd_i.seed) begin
      sx_q  <= AW'(q_sx);
      sy_q  <= AW'(q_sy);
      dlx_q <= q_dlx;
      dly_q <= q_dly;
    end
    if (cmd_i.step) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      oob_q  <= oob_d;
      side_q <= !take_x;
      if (take_x) begin
        dist_q <= sx_q;
        sx_q   <= sx_q + AW'(dlx_q);
      end else begin
        dist_q <= sy_q;
        sy_q   <= sy_q + AW'(dly_q);
      end
    end
    if (cmd_i.check && !oob_q && rdata_q != '0) begin
      hit_q  <= 1'b1;
      kind_q <= rdata_q;
    end
    if (cmd_i.mul)
      prod_q <= 32'(dist_q[31:0] * magn(side_q ? dx_q : dy_q));
  end

  // tile memory
  logic [grdc_pkg::TILE_W-1:0] mem_q [2**grdc_pkg::ADDR_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) mem_q[in_idx] <= in_val;
    else             rdata_q <= mem_q[raddr];
  end

  // result
  logic [F-1:0]                coord_lo, frac;
  logic [grdc_pkg::TEX_BITS-1:0] tex;
  logic                        mirror, d_neg;
  logic [grdc_pkg::DIST_W-1:0] dsat;
  logic [grdc_pkg::OUT_DATA_W-1:0] res;
  logic                        out_valid_q;
  logic [grdc_pkg::OUT_DATA_W-1:0] out_data_q;

  always_comb begin
    d_neg    = side_q ? dx_q[DW-1] : dy_q[DW-1];
    coord_lo = side_q ? ox_q[F-1:0] : oy_q[F-1:0];
    frac     = d_neg ? coord_lo - prod_q[2*F-1:F] : coord_lo + prod_q[2*F-1:F];
    tex      = frac[F-1 -: grdc_pkg::TEX_BITS];
    mirror   = (!side_q && !dx_q[DW-1] && dx_q != '0) || (side_q && dy_q[DW-1]);
    if (mirror) tex = ~tex;
    dsat = |dist_q[AW-1:grdc_pkg::DIST_W] ? '1 : dist_q[grdc_pkg::DIST_W-1:0];
    if (zero_q)
      res = {cy_q, cx_q, 5'd0, 16'd0, 8'd0, 1'b0, 1'b0, {grdc_pkg::DIST_W{1'b1}}};
    else
      res = {cy_q, cx_q, tex, frac, kind_q, hit_q, side_q, dsat};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_valid_q <= 1'b0;
    else if (cmd_i.fin)   out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) out_data_q <= res;
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign sts_o.zero_dir  = in_dx == '0 && in_dy == '0;
  assign sts_o.div_done  = dn_sx && dn_sy && dn_dlx && dn_dly;
  assign sts_o.oob       = oob_q;
  assign sts_o.tile_hit  = rdata_q != '0;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

`ifndef ASSERT_OFF
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  a_no_zero_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !zero_q) else $error("zero ray stepped");
  a_seed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.seed |-> $past(sts_o.div_done) || sts_o.div_done) else $error("seed before divide");
  a_load_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> !sts_o.div_done) else $error("divider not restarted");
`endif

endmodule
